// ===== rtl/core/eight_bit_alu_with_flags_macros.svh =====
// assertion macros shared by the alu checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// checked at every edge, reset included
`define EALU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// checked only while out of reset
`define EALU_ASSERT(label, prop, msg) \
  `EALU_ASSERT_ALWAYS(label, disable iff (!rst_ni) prop, msg)

`endif

// ===== rtl/core/ealu_pkg.sv =====
// types, opcodes and flag positions of the eight-bit alu
// no dependencies
`default_nettype none

package ealu_pkg;

  // opcodes, codes 24 to 31 are unused
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SWAP  = 5'd16,
    OP_SRL   = 5'd17,
    OP_BIT   = 5'd18,
    OP_RES   = 5'd19,
    OP_SET   = 5'd20,
    OP_ADDHL = 5'd21,
    OP_ADDSP = 5'd22,
    OP_LDHL  = 5'd23
  } action_e;

  // flag positions in the four-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // operation, first member in the highest bits
  typedef struct packed {
    logic [3:0]  flags_in;
    logic [2:0]  bit_index;
    logic [15:0] wide_operand;
    logic [15:0] wide_base;
    logic [7:0]  byte_operand;
    logic [7:0]  acc_in;
    action_e     action;
  } alu_in_t;

  // result, first member in the highest bits
  typedef struct packed {
    logic [3:0]  flags_out;
    logic [15:0] wide_result;
    logic [7:0]  byte_result;
  } alu_out_t;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned IN_BITS     = $bits(alu_in_t);
  localparam int unsigned OUT_BITS    = $bits(alu_out_t);

endpackage

`default_nettype wire

// ===== rtl/core/ealu_core.sv =====
// combinational alu datapath: byte ops, rotates, bit ops and wide adds
// depends on ealu_pkg
`default_nettype none

module ealu_core
  import ealu_pkg::*;
(
  input  alu_in_t  op_i,
  output alu_out_t res_o
);

  logic [7:0]  a;
  logic [7:0]  v;
  logic        cin;
  logic        c;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sext;
  logic [7:0]  bmask;
  logic [7:0]  r;
  logic [15:0] wr;
  logic [3:0]  f;

  assign a     = op_i.acc_in;
  assign v     = op_i.byte_operand;
  assign cin   = op_i.flags_in[FLAG_C];
  assign c     = cin && ((op_i.action == OP_ADC) || (op_i.action == OP_SBC));
  assign bmask = 8'(8'd1 << op_i.bit_index);

  // shared adders, carries come out of the top bit
  assign sum9  = {1'b0, a} + {1'b0, v} + {8'd0, c};
  assign sum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
  assign dif9  = {1'b0, a} - {1'b0, v} - {8'd0, c};
  assign dif5  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
  assign sum17 = {1'b0, op_i.wide_base} + {1'b0, op_i.wide_operand};
  assign sum13 = {1'b0, op_i.wide_base[11:0]} + {1'b0, op_i.wide_operand[11:0]};
  assign sext  = {{8{v[7]}}, v};

  // opcode decode, untouched flags pass through
  always_comb begin
    r  = 8'd0;
    wr = 16'd0;
    f  = op_i.flags_in;
    unique case (op_i.action) inside
      OP_ADD, OP_ADC: begin
        r         = sum9[7:0];
        f[FLAG_Z] = (sum9[7:0] == 8'd0);
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = sum5[4];
        f[FLAG_C] = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r         = dif9[7:0];
        f[FLAG_Z] = (dif9[7:0] == 8'd0);
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = dif5[4];
        f[FLAG_C] = dif9[8];
      end
      OP_AND: begin
        r = a & v;
        f = {(r == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r = a ^ v;
        f = {(r == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_OR: begin
        r = a | v;
        f = {(r == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_INC: begin
        r         = v + 8'd1;
        f[FLAG_Z] = (r == 8'd0);
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = (v[3:0] == 4'hF);
      end
      OP_DEC: begin
        r         = v - 8'd1;
        f[FLAG_Z] = (r == 8'd0);
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = (v[3:0] == 4'h0);
      end
      OP_RLC: begin
        r = {v[6:0], v[7]};
        f = {(r == 8'd0), 1'b0, 1'b0, v[7]};
      end
      OP_RRC: begin
        r = {v[0], v[7:1]};
        f = {(r == 8'd0), 1'b0, 1'b0, v[0]};
      end
      OP_RL: begin
        r = {v[6:0], cin};
        f = {(r == 8'd0), 1'b0, 1'b0, v[7]};
      end
      OP_RR: begin
        r = {cin, v[7:1]};
        f = {(r == 8'd0), 1'b0, 1'b0, v[0]};
      end
      OP_SLA: begin
        r = {v[6:0], 1'b0};
        f = {(r == 8'd0), 1'b0, 1'b0, v[7]};
      end
      OP_SRA: begin
        r = {v[7], v[7:1]};
        f = {(r == 8'd0), 1'b0, 1'b0, v[0]};
      end
      OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        f = {(r == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_SRL: begin
        r = {1'b0, v[7:1]};
        f = {(r == 8'd0), 1'b0, 1'b0, v[0]};
      end
      OP_BIT: begin
        r         = v;
        f[FLAG_Z] = ((v & bmask) == 8'd0);
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b1;
      end
      OP_RES: begin
        r = v & ~bmask;
      end
      OP_SET: begin
        r = v | bmask;
      end
      OP_ADDHL: begin
        wr        = sum17[15:0];
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = sum13[12];
        f[FLAG_C] = sum17[16];
      end
      OP_ADDSP, OP_LDHL: begin
        // half and full carry from the unsigned low byte sum
        wr        = op_i.wide_base + sext;
        f[FLAG_Z] = 1'b0;
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 5'({1'b0, op_i.wide_base[3:0]} + {1'b0, v[3:0]}) > 5'h0F;
        f[FLAG_C] = 9'({1'b0, op_i.wide_base[7:0]} + {1'b0, v}) > 9'h0FF;
      end
      default: begin
        r  = 8'd0;
        wr = 16'd0;
        f  = op_i.flags_in;
      end
    endcase
  end

  assign res_o.byte_result = r;
  assign res_o.wide_result = wr;
  assign res_o.flags_out   = f;

endmodule

`default_nettype wire

// ===== rtl/core/eight_bit_alu_with_flags.sv =====
// an accepted input beat passes the operand register, then the result register, to its result beat
// throughput: one beat per cycle while the sink accepts results, set by the single input and result register pair
// the input register refills whenever the result register is empty or being drained
// reset clears both valid flags; data registers keep their contents
// depends on ealu_pkg and ealu_core
`default_nettype none

module eight_bit_alu_with_flags
  import ealu_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  // action, acc_in, byte_operand, wide_base, wide_operand, bit_index, flags_in, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // byte_result, wide_result, flags_out, zero pad
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic     in_vld_q;
  logic     in_vld_d;
  alu_in_t  in_q;
  logic     out_vld_q;
  logic     out_vld_d;
  alu_out_t out_q;
  alu_out_t res;
  logic     adv;
  logic     take;

  // stage moves when the result register is free or draining
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  assign in_vld_d  = take || (in_vld_q && !adv);
  assign out_vld_d = adv ? in_vld_q : out_vld_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // operand register
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= alu_in_t'(s_axis_tdata_i[IN_BITS-1:0]);
    end
  end

  ealu_core u_core (
    .op_i  (in_q),
    .res_o (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_q};

endmodule

`default_nettype wire

// ===== rtl/core/ealu_checker.sv =====
// port-level checks of the alu stream handshake and pipeline timing
// depends on ealu_pkg and eight_bit_alu_with_flags_macros.svh
`default_nettype none
`include "eight_bit_alu_with_flags_macros.svh"

module ealu_checker
  import ealu_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // no result beat offered on the edge after reset is seen
  `EALU_ASSERT_ALWAYS(a_no_vld_in_rst, !rst_ni |=> !m_axis_tvalid_o, "result valid in reset")

  // a stalled result beat stays offered
  `EALU_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result beat dropped")

  // a draining sink never blocks the input side
  `EALU_ASSERT(a_ready_flow, m_axis_tready_i |-> s_axis_tready_o, "input stalled while output drains")

  // with the sink ready an accepted beat shows up once it has passed the operand and result registers
  `EALU_ASSERT(a_latency, s_axis_tvalid_i && s_axis_tready_o && m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o, "result late")

endmodule

bind eight_bit_alu_with_flags ealu_checker u_checker (.*);

`default_nettype wire

// ===== dv/eight_bit_alu_with_flags_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for eight_bit_alu_with_flags: directed corners, random ops, stalls
// predicts each result beat from the op beat and compares it field by field
// depends on ealu_pkg and the eight_bit_alu_with_flags rtl

module eight_bit_alu_with_flags_tb;
  import ealu_pkg::*;

  localparam int unsigned CLK_HALF_NS       = 5;
  localparam int unsigned RESET_CYCLES      = 2;
  localparam int unsigned LONG_STALL_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES      = 10;
  localparam int unsigned IDLE_LIMIT        = 2000;
  localparam int unsigned RANDOM_OPS        = 600;
  localparam int unsigned BURST_OPS         = 60;
  localparam int unsigned BACKPRESSURE_OPS  = 60;
  // codes past the last opcode, the block must pass flags through and give zero results
  localparam logic [4:0]  ACT_FIRST_UNUSED  = 5'd24;
  localparam logic [4:0]  ACT_LAST_UNUSED   = 5'd31;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // action, acc_in, byte_operand, wide_base, wide_operand, bit_index, flags_in, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // byte_result, wide_result, flags_out, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  alu_out_t    pending_alu_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          no_sender_gaps = 1'b0;
  bit          no_receiver_stalls = 1'b0;
  bit          long_stall_req = 1'b0;

  eight_bit_alu_with_flags uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // z from the byte, n and h cleared, c as given
  function automatic logic [3:0] zero_carry_flags(logic [3:0] f, logic [7:0] r, logic c);
    f[FLAG_Z] = (r == 8'h00);
    f[FLAG_N] = 1'b0;
    f[FLAG_H] = 1'b0;
    f[FLAG_C] = c;
    return f;
  endfunction

  // expected result beat for one op
  function automatic alu_out_t alu_result_of(alu_in_t op);
    logic [7:0]  a, v, r;
    logic [15:0] base, w, wr, offset;
    logic [3:0]  f;
    logic        cin, c;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    alu_out_t    res;
    a    = op.acc_in;
    v    = op.byte_operand;
    base = op.wide_base;
    w    = op.wide_operand;
    f    = op.flags_in;
    cin  = f[FLAG_C];
    r    = 8'h00;
    wr   = 16'h0000;
    case (op.action)
      OP_ADD, OP_ADC: begin
        c    = (op.action == OP_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + {8'h00, c};
        nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, c};
        r    = sum9[7:0];
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = nib[4];
        f[FLAG_C] = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        c = (op.action == OP_SBC) ? cin : 1'b0;
        r = a - v - {7'h00, c};
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = ({1'b0, a[3:0]} < {1'b0, v[3:0]} + {4'h0, c});
        f[FLAG_C] = ({1'b0, a} < {1'b0, v} + {8'h00, c});
      end
      OP_AND: begin
        r = a & v;
        f = zero_carry_flags(f, r, 1'b0);
        f[FLAG_H] = 1'b1;
      end
      OP_XOR: begin
        r = a ^ v;
        f = zero_carry_flags(f, r, 1'b0);
      end
      OP_OR: begin
        r = a | v;
        f = zero_carry_flags(f, r, 1'b0);
      end
      // inc and dec leave carry alone
      OP_INC: begin
        r = v + 8'h01;
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = (v[3:0] == 4'hF);
      end
      OP_DEC: begin
        r = v - 8'h01;
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = (v[3:0] == 4'h0);
      end
      OP_RLC: begin
        r = {v[6:0], v[7]};
        f = zero_carry_flags(f, r, v[7]);
      end
      OP_RRC: begin
        r = {v[0], v[7:1]};
        f = zero_carry_flags(f, r, v[0]);
      end
      OP_RL: begin
        r = {v[6:0], cin};
        f = zero_carry_flags(f, r, v[7]);
      end
      OP_RR: begin
        r = {cin, v[7:1]};
        f = zero_carry_flags(f, r, v[0]);
      end
      // zero flag taken from the truncated byte
      OP_SLA: begin
        r = {v[6:0], 1'b0};
        f = zero_carry_flags(f, r, v[7]);
      end
      OP_SRA: begin
        r = {v[7], v[7:1]};
        f = zero_carry_flags(f, r, v[0]);
      end
      OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        f = zero_carry_flags(f, r, 1'b0);
      end
      OP_SRL: begin
        r = {1'b0, v[7:1]};
        f = zero_carry_flags(f, r, v[0]);
      end
      OP_BIT: begin
        r = v;
        f[FLAG_Z] = ~v[op.bit_index];
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b1;
      end
      OP_RES: begin
        r = v;
        r[op.bit_index] = 1'b0;
      end
      OP_SET: begin
        r = v;
        r[op.bit_index] = 1'b1;
      end
      // half carry out of bit 11, zero untouched
      OP_ADDHL: begin
        sum17 = {1'b0, base} + {1'b0, w};
        sum13 = {1'b0, base[11:0]} + {1'b0, w[11:0]};
        wr    = sum17[15:0];
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = sum13[12];
        f[FLAG_C] = sum17[16];
      end
      // signed offset, flags from the unsigned low-byte sum
      OP_ADDSP, OP_LDHL: begin
        offset = {{8{v[7]}}, v};
        wr     = base + offset;
        nib    = {1'b0, base[3:0]} + {1'b0, v[3:0]};
        sum9   = {1'b0, base[7:0]} + {1'b0, v};
        f[FLAG_Z] = 1'b0;
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = nib[4];
        f[FLAG_C] = sum9[8];
      end
      default: begin
      end
    endcase
    res.byte_result = r;
    res.wide_result = wr;
    res.flags_out   = f;
    return res;
  endfunction

  // bytes biased toward carry and sign corners
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h0F;
      3: return 8'h10;
      4: return 8'h7F;
      5: return 8'h80;
      6: return 8'hF0;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h00FF;
      3: return 16'h0FFF;
      4: return 16'h1000;
      5: return 16'h7FFF;
      6: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic alu_in_t random_op();
    alu_in_t op;
    if ($urandom_range(0, 99) < 97) begin
      op.action = action_e'($urandom_range(OP_ADD, OP_LDHL));
    end else begin
      op.action = action_e'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
    end
    op.acc_in       = pick_byte();
    op.byte_operand = pick_byte();
    op.wide_base    = pick_word();
    op.wide_operand = pick_word();
    op.bit_index    = 3'($urandom_range(0, 7));
    op.flags_in     = 4'($urandom_range(0, 15));
    return op;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one op beat, wait for the handshake, then idle for a random gap, which may be zero
  task automatic send_op(alu_in_t op);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_alu_results.push_back(alu_result_of(op));
    gap = no_sender_gaps ? 0 : random_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_fields(action_e act, logic [7:0] a, logic [7:0] v, logic [15:0] base,
                             logic [15:0] w, logic [2:0] idx, logic [3:0] f);
    alu_in_t op;
    op.action       = act;
    op.acc_in       = a;
    op.byte_operand = v;
    op.wide_base    = base;
    op.wide_operand = w;
    op.bit_index    = idx;
    op.flags_in     = f;
    send_op(op);
  endtask

  // two-operand arithmetic and logic corners
  task automatic test_byte_arith_logic();
    send_fields(OP_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_ADD, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
    send_fields(OP_ADC, 8'h0F, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h1);
    send_fields(OP_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_SBC, 8'h10, 8'h0F, 16'h0000, 16'h0000, 3'd0, 4'h1);
    send_fields(OP_CP,  8'h5A, 8'h5A, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_AND, 8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_XOR, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'hF);
    send_fields(OP_OR,  8'h80, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'hF);
  endtask

  // single-operand ops, including the shift-left zero flag
  task automatic test_shift_rotate();
    send_fields(OP_INC,  8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'h1);
    send_fields(OP_DEC,  8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_RLC,  8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_RRC,  8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_RL,   8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'h1);
    send_fields(OP_RR,   8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_SLA,  8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_SRA,  8'h00, 8'h81, 16'h0000, 16'h0000, 3'd0, 4'hF);
    send_fields(OP_SWAP, 8'h00, 8'hF0, 16'h0000, 16'h0000, 3'd0, 4'hF);
    send_fields(OP_SRL,  8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
  endtask

  // bit test, reset and set; bit test returns the operand unchanged
  task automatic test_bit_ops();
    send_fields(OP_BIT, 8'h00, 8'h7F, 16'h0000, 16'h0000, 3'd7, 4'h0);
    send_fields(OP_RES, 8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'hF);
    send_fields(OP_SET, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd7, 4'h0);
  endtask

  // wide adds: bit 11 half carry, signed offsets at both ends
  task automatic test_wide_adds();
    send_fields(OP_ADDHL, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 3'd0, 4'h8);
    send_fields(OP_ADDHL, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 3'd0, 4'h0);
    send_fields(OP_ADDSP, 8'h00, 8'h01, 16'h00FF, 16'h0000, 3'd0, 4'hF);
    send_fields(OP_ADDSP, 8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'h0);
    send_fields(OP_LDHL,  8'h00, 8'hFF, 16'hFFFF, 16'h0000, 3'd0, 4'hF);
  endtask

  // codes past the last opcode pass flags through
  task automatic test_unused_opcodes();
    send_fields(action_e'(ACT_FIRST_UNUSED), 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'hA);
    send_fields(action_e'(ACT_LAST_UNUSED),  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'h5);
  endtask

  task automatic test_random_mix(int unsigned count);
    repeat (count) send_op(random_op());
  endtask

  // both sides always ready for full-rate streaming
  task automatic test_back_to_back(int unsigned count);
    no_sender_gaps     = 1'b1;
    no_receiver_stalls = 1'b1;
    repeat (count) send_op(random_op());
    no_sender_gaps     = 1'b0;
    no_receiver_stalls = 1'b0;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure(int unsigned count);
    no_sender_gaps = 1'b1;
    long_stall_req = 1'b1;
    repeat (count) send_op(random_op());
    no_sender_gaps = 1'b0;
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin : drive_result_ready
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        m_axis_tready_i <= 1'b0;
        long_stall_req = 1'b0;
        repeat (LONG_STALL_CYCLES) @(negedge clk_i);
      end else if (stall_left > 0 && !no_receiver_stalls) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = no_receiver_stalls ? 0 : random_gap();
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    alu_out_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[OUT_BITS-1:0];
      if (pending_alu_results.size() == 0) begin
        $error("result beat with no op pending: %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_alu_results.pop_front();
        if (got.byte_result !== want.byte_result) begin
          $error("byte_result mismatch: expected %h, actual %h",
                 want.byte_result, got.byte_result);
          error_count++;
        end
        if (got.wide_result !== want.wide_result) begin
          $error("wide_result mismatch: expected %h, actual %h",
                 want.wide_result, got.wide_result);
          error_count++;
        end
        if (got.flags_out !== want.flags_out) begin
          $error("flags_out mismatch: expected %b, actual %b", want.flags_out, got.flags_out);
          error_count++;
        end
      end
    end
  end

  // cycles since the last beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_byte_arith_logic();
    test_shift_rotate();
    test_bit_ops();
    test_wide_adds();
    test_unused_opcodes();
    test_random_mix(RANDOM_OPS);
    test_back_to_back(BURST_OPS);
    test_output_backpressure(BACKPRESSURE_OPS);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_alu_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_alu_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
